@@ design/otr_pkg.sv @@
package otr_pkg;

  // field widths fixed by the item formats
  localparam int COORD_W       = 14;
  localparam int CNT_CFG_W     = 7;
  localparam int OVL_W         = 10;
  localparam int IDX_W         = 6;
  localparam int CFG_DATA_W    = 14;
  localparam int CFG_IDX_W     = 3;
  localparam int OVL_FRAC_BITS = 8;

  // datapath widths
  localparam int DIV_W   = COORD_W + 7;
  localparam int RCP_W   = DIV_W + 1;
  localparam int MARG_W  = COORD_W + 2;
  localparam int MGSUM_W = COORD_W + OVL_W + 1;

  // pipeline layout
  localparam int NUM_STAGES  = 7;
  localparam int AXIS_STAGES = 6;
  localparam int DIV_STAGES  = 3;

  localparam int MAX_TILES_DEF = 64;

  // stream widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 120;

  // register reset values
  localparam logic [COORD_W-1:0]   RST_IMAGE_WIDTH  = COORD_W'(1920);
  localparam logic [COORD_W-1:0]   RST_IMAGE_HEIGHT = COORD_W'(1080);
  localparam logic [CNT_CFG_W-1:0] RST_TILES        = CNT_CFG_W'(1);
  localparam logic [OVL_W-1:0]     RST_OVERLAP      = '0;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_TILES_ACROSS = 3'd2,
    CFG_TILES_DOWN   = 3'd3,
    CFG_OVERLAP      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0]   image_width;
    logic [COORD_W-1:0]   image_height;
    logic [CNT_CFG_W-1:0] tiles_across;
    logic [CNT_CFG_W-1:0] tiles_down;
    logic [OVL_W-1:0]     overlap_fraction;
  } cfg_t;

  // one axis of the result, out of grid flag included
  typedef struct packed {
    logic               oor;
    logic [COORD_W-1:0] inner_pos;
    logic [COORD_W-1:0] inner_len;
    logic [COORD_W-1:0] outer_pos;
    logic [COORD_W-1:0] outer_len;
  } axis_span_t;

  // first field of the item format, declared last, in the lowest bits
  typedef struct packed {
    logic [IN_DATA_W-2*IDX_W-1:0] pad;
    logic [IDX_W-1:0]             tile_row;
    logic [IDX_W-1:0]             tile_col;
  } in_item_t;

  typedef struct packed {
    logic [OUT_DATA_W-8*COORD_W-2:0] pad;
    logic [COORD_W-1:0]              inner_height;
    logic [COORD_W-1:0]              inner_width;
    logic [COORD_W-1:0]              inner_y;
    logic [COORD_W-1:0]              inner_x;
    logic [COORD_W-1:0]              outer_height;
    logic [COORD_W-1:0]              outer_width;
    logic [COORD_W-1:0]              outer_y;
    logic [COORD_W-1:0]              outer_x;
    logic                            index_error;
  } out_item_t;

endpackage

@@ design/overlapped_tile_rectangle_unit.sv @@
// channel   dir  tdata fields (lsb first)                                 tuser
// s_axis    in   tile_col[5:0] tile_row[11:6]                             -
// m_axis    out  index_error[0] outer_x outer_y outer_width outer_height  -
//                inner_x inner_y inner_width inner_height (14 bits each)
// cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i, write only
//
// seven register stages; an item may enter every cycle unless every stage
// holds an item and m_axis_tready_i is low
// the reciprocal divider works in steps: multiply, multiply back, correct
// each stage holds when it is full and the one after it cannot move, so
// bubbles close up and an item is taken while a result waits at the output
// rst_ni clears valid bits and sets register defaults; payload is not reset
module overlapped_tile_rectangle_unit #(
  parameter int MAX_TILES = otr_pkg::MAX_TILES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tile_col, tile_row
  input  logic [otr_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // index_error, outer_x, outer_y, outer_width, outer_height,
  // inner_x, inner_y, inner_width, inner_height
  output logic [otr_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic                             cfg_we_i,
  input  logic [otr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [otr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import otr_pkg::*;

  localparam int OUT_STG = NUM_STAGES - 1;

  cfg_t                  cfg;
  in_item_t              in_item;
  axis_span_t            span_x, span_y;
  logic [NUM_STAGES-1:0] stg_en;
  logic [NUM_STAGES-1:0] vld_q;
  logic                  err;
  out_item_t             out_q, out_d;

  otr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign in_item = s_axis_tdata_i;

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    stg_en[OUT_STG] = !vld_q[OUT_STG] || m_axis_tready_i;
    for (int k = OUT_STG - 1; k >= 0; k--) begin
      stg_en[k] = !vld_q[k] || stg_en[k+1];
    end
  end

  assign s_axis_tready_o = stg_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stg_en[0]) vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (stg_en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // column axis
  otr_axis #(
    .MAX_TILES (MAX_TILES)
  ) u_axis_x (
    .clk_i   (clk_i),
    .en_i    (stg_en[AXIS_STAGES-1:0]),
    .size_i  (cfg.image_width),
    .count_i (cfg.tiles_across),
    .ovl_i   (cfg.overlap_fraction),
    .idx_i   (in_item.tile_col),
    .span_o  (span_x)
  );

  // row axis
  otr_axis #(
    .MAX_TILES (MAX_TILES)
  ) u_axis_y (
    .clk_i   (clk_i),
    .en_i    (stg_en[AXIS_STAGES-1:0]),
    .size_i  (cfg.image_height),
    .count_i (cfg.tiles_down),
    .ovl_i   (cfg.overlap_fraction),
    .idx_i   (in_item.tile_row),
    .span_o  (span_y)
  );

  // result assembly, zeroed when out of grid
  assign err = span_x.oor || span_y.oor;

  always_comb begin
    out_d              = '0;
    out_d.index_error  = err;
    if (!err) begin
      out_d.outer_x      = span_x.outer_pos;
      out_d.outer_y      = span_y.outer_pos;
      out_d.outer_width  = span_x.outer_len;
      out_d.outer_height = span_y.outer_len;
      out_d.inner_x      = span_x.inner_pos;
      out_d.inner_y      = span_y.inner_pos;
      out_d.inner_width  = span_x.inner_len;
      out_d.inner_height = span_y.inner_len;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[OUT_STG]) out_q <= out_d;
  end

  assign m_axis_tdata_o  = out_q;
  assign m_axis_tvalid_o = vld_q[OUT_STG];

  // an error result carries nothing else
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_q.index_error |-> out_q[OUT_DATA_W-1:1] == '0)
    else $error("error item with nonzero fields");

  // the outer tile covers the inner one
  a_outer_covers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_q.outer_x <= out_q.inner_x &&
                        out_q.outer_y <= out_q.inner_y &&
                        out_q.outer_width >= out_q.inner_width &&
                        out_q.outer_height >= out_q.inner_height)
    else $error("outer tile does not cover inner tile");

  // input is refused only when every stage holds an item
  a_full_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> &vld_q)
    else $error("input stalled with a free stage");

  // a taken item lands in the first stage
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[0])
    else $error("accepted item lost at entry");

endmodule

@@ design/otr_cfg.sv @@
module otr_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [otr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [otr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output otr_pkg::cfg_t                    cfg_o
);
  import otr_pkg::*;

  cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  cfg_d.image_width      = cfg_wdata_i[COORD_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_d.image_height     = cfg_wdata_i[COORD_W-1:0];
        CFG_TILES_ACROSS: cfg_d.tiles_across     = cfg_wdata_i[CNT_CFG_W-1:0];
        CFG_TILES_DOWN:   cfg_d.tiles_down       = cfg_wdata_i[CNT_CFG_W-1:0];
        CFG_OVERLAP:      cfg_d.overlap_fraction = cfg_wdata_i[OVL_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width      <= RST_IMAGE_WIDTH;
      cfg_q.image_height     <= RST_IMAGE_HEIGHT;
      cfg_q.tiles_across     <= RST_TILES;
      cfg_q.tiles_down       <= RST_TILES;
      cfg_q.overlap_fraction <= RST_OVERLAP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/otr_rdiv.sv @@
module otr_rdiv (
  input  logic                          clk_i,
  input  logic [otr_pkg::DIV_STAGES-1:0] en_i,
  input  logic [otr_pkg::DIV_W-1:0]     num_i,
  input  logic [otr_pkg::RCP_W-1:0]     rcp_i,
  input  logic [otr_pkg::DIV_W-1:0]     den_i,
  output logic [otr_pkg::DIV_W-1:0]     quo_o
);
  import otr_pkg::*;

  localparam int PROD_W = DIV_W + RCP_W;

  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  qe_q, qe_d;
  logic [DIV_W-1:0]  num1_q, num2_q;
  logic [DIV_W-1:0]  qe2_q;
  logic [DIV_W-1:0]  back_q, back_d;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  quo_q, quo_d;

  // estimate by reciprocal, low by at most one
  assign prod = PROD_W'(num_i) * PROD_W'(rcp_i);
  assign qe_d = prod[DIV_W +: DIV_W];

  // multiply back to get the remainder
  assign back_d = DIV_W'(qe_q * den_i);

  // one correction step
  assign rem   = num2_q - back_q;
  assign quo_d = (rem >= den_i) ? qe2_q + DIV_W'(1) : qe2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      qe_q   <= qe_d;
      num1_q <= num_i;
    end
    if (en_i[1]) begin
      back_q <= back_d;
      qe2_q  <= qe_q;
      num2_q <= num1_q;
    end
    if (en_i[2]) begin
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

@@ design/otr_axis.sv @@
module otr_axis #(
  parameter int MAX_TILES = otr_pkg::MAX_TILES_DEF
) (
  input  logic                            clk_i,
  input  logic [otr_pkg::AXIS_STAGES-1:0] en_i,
  input  logic [otr_pkg::COORD_W-1:0]     size_i,
  input  logic [otr_pkg::CNT_CFG_W-1:0]   count_i,
  input  logic [otr_pkg::OVL_W-1:0]       ovl_i,
  input  logic [otr_pkg::IDX_W-1:0]       idx_i,
  output otr_pkg::axis_span_t             span_o
);
  import otr_pkg::*;

  localparam int CNT_W = $clog2(MAX_TILES + 1);

  // reciprocal table, floor(2^DIV_W / n)
  logic [RCP_W-1:0] rcp_tbl [MAX_TILES+1];
  for (genvar Dv = 0; Dv <= MAX_TILES; Dv++) begin : g_rcp
    localparam logic [RCP_W-1:0] Rcp =
      (Dv == 0) ? '0 : RCP_W'((64'd1 << DIV_W) / ((Dv == 0) ? 1 : Dv));
    assign rcp_tbl[Dv] = Rcp;
  end

  logic [CNT_W-1:0]   cnt;
  logic [DIV_W-1:0]   den;
  logic [RCP_W-1:0]   rcp;
  logic               oor_d;
  logic [MGSUM_W-1:0] mg_sum;
  logic [DIV_W-1:0]   num_st_d, num_ln_d, num_mg_d;
  logic [DIV_W-1:0]   num_st_q, num_ln_q, num_mg_q;
  logic               oor_q [AXIS_STAGES];
  logic [DIV_W-1:0]   quo_st, quo_ln, quo_mg;

  logic [COORD_W-1:0] st_c, ln_c;
  logic [MARG_W-1:0]  mg_c;
  logic [COORD_W:0]   sum_c;
  logic [COORD_W-1:0] end4_d, lo4_d;
  logic [COORD_W-1:0] st4_q, end4_q, lo4_q;
  logic [MARG_W-1:0]  mg4_q;

  logic [MARG_W:0]    hsum;
  logic [COORD_W-1:0] hi5_d, len5_d;
  logic [COORD_W-1:0] st5_q, lo5_q, hi5_q, len5_q;

  // tile count saturates at the grid limit
  assign cnt   = (int'(count_i) > MAX_TILES) ? CNT_W'(MAX_TILES) : CNT_W'(count_i);
  assign den   = DIV_W'(cnt);
  assign rcp   = rcp_tbl[cnt];
  assign oor_d = int'(idx_i) >= int'(cnt);

  // numerators with the rounding half folded in
  assign num_st_d = DIV_W'(size_i) * DIV_W'(idx_i) + DIV_W'(cnt >> 1);
  assign num_ln_d = DIV_W'(size_i) + DIV_W'(cnt >> 1);
  assign mg_sum   = MGSUM_W'(size_i) * MGSUM_W'(ovl_i)
                  + (MGSUM_W'(cnt) << (OVL_FRAC_BITS - 1));
  assign num_mg_d = DIV_W'(mg_sum >> OVL_FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      num_st_q  <= num_st_d;
      num_ln_q  <= num_ln_d;
      num_mg_q  <= num_mg_d;
      oor_q[0]  <= oor_d;
    end
    for (int k = 1; k < AXIS_STAGES; k++) begin
      if (en_i[k]) oor_q[k] <= oor_q[k-1];
    end
  end

  // divisions by the tile count
  otr_rdiv u_div_start (
    .clk_i (clk_i),
    .en_i  (en_i[DIV_STAGES:1]),
    .num_i (num_st_q),
    .rcp_i (rcp),
    .den_i (den),
    .quo_o (quo_st)
  );

  otr_rdiv u_div_len (
    .clk_i (clk_i),
    .en_i  (en_i[DIV_STAGES:1]),
    .num_i (num_ln_q),
    .rcp_i (rcp),
    .den_i (den),
    .quo_o (quo_ln)
  );

  otr_rdiv u_div_margin (
    .clk_i (clk_i),
    .en_i  (en_i[DIV_STAGES:1]),
    .num_i (num_mg_q),
    .rcp_i (rcp),
    .den_i (den),
    .quo_o (quo_mg)
  );

  // inner end trimmed at the image edge, outer start clamped at zero
  assign st_c   = quo_st[COORD_W-1:0];
  assign ln_c   = quo_ln[COORD_W-1:0];
  assign mg_c   = quo_mg[MARG_W-1:0];
  assign sum_c  = {1'b0, st_c} + {1'b0, ln_c};
  assign end4_d = (sum_c > {1'b0, size_i}) ? size_i : sum_c[COORD_W-1:0];
  assign lo4_d  = (MARG_W'(st_c) >= mg_c) ? COORD_W'(MARG_W'(st_c) - mg_c) : '0;

  always_ff @(posedge clk_i) begin
    if (en_i[DIV_STAGES+1]) begin
      st4_q  <= st_c;
      end4_q <= end4_d;
      lo4_q  <= lo4_d;
      mg4_q  <= mg_c;
    end
  end

  // outer end clamped at the image edge, trimmed inner size
  assign hsum   = (MARG_W+1)'(end4_q) + (MARG_W+1)'(mg4_q);
  assign hi5_d  = (hsum > (MARG_W+1)'(size_i)) ? size_i : hsum[COORD_W-1:0];
  assign len5_d = end4_q - st4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[DIV_STAGES+2]) begin
      st5_q  <= st4_q;
      lo5_q  <= lo4_q;
      hi5_q  <= hi5_d;
      len5_q <= len5_d;
    end
  end

  assign span_o.oor       = oor_q[AXIS_STAGES-1];
  assign span_o.inner_pos = st5_q;
  assign span_o.inner_len = len5_q;
  assign span_o.outer_pos = lo5_q;
  assign span_o.outer_len = hi5_q - lo5_q;

endmodule
